// ===== sv/sound_slot_mixer_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SOUND_SLOT_MIXER_MACROS_SVH
`define SOUND_SLOT_MIXER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sound slot mixer check failed");

// Next-cycle implication, disabled while reset is high.
`define SSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sound slot mixer check failed");

// Same-cycle implication that is also checked around reset.
`define SSM_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("sound slot mixer check failed");

`endif

// ===== sv/ssm_pkg.sv =====
`timescale 1ns / 1ps
package ssm_pkg;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 4;
   localparam int VOL_W    = 10;
   localparam int LEN_W    = 24;
   localparam int ID_W     = 8;
   localparam int SAMPLE_W = 16;
   localparam int STATUS_W = 2;

   localparam int SLOTS_DEFAULT       = 8;
   localparam int FULL_VOLUME_DEFAULT = 128;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [OP_W-1:0] OP_PLAY    = 3'd0;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP_ID = 3'd2;
   localparam logic [OP_W-1:0] OP_PAUSE   = 3'd3;
   localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;
   localparam logic [OP_W-1:0] OP_MIX     = 3'd6;

   localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PLAYING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PAUSED  = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

   typedef struct packed {
      logic [OP_W-1:0]            operation;
      logic [SLOT_W-1:0]          slot;
      logic                       slot_ok;
      logic                       all_slots;
      logic [VOL_W-1:0]           volume;
      logic [LEN_W-1:0]           sound_length;
      logic                       sound_mono;
      logic [ID_W-1:0]            sound_id;
      logic signed [SAMPLE_W-1:0] source_sample;
      logic signed [SAMPLE_W-1:0] dest_sample_a;
      logic signed [SAMPLE_W-1:0] dest_sample_b;
   } ssm_cmd_type;

endpackage

// ===== sv/ssm_if.sv =====
`timescale 1ns / 1ps
interface ssm_req_if;
   import ssm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic [SLOT_W-1:0]          slot;
   logic                       all_slots;
   logic [VOL_W-1:0]           volume;
   logic [LEN_W-1:0]           sound_length;
   logic                       sound_mono;
   logic [ID_W-1:0]            sound_id;
   logic signed [SAMPLE_W-1:0] source_sample;
   logic signed [SAMPLE_W-1:0] dest_sample_a;
   logic signed [SAMPLE_W-1:0] dest_sample_b;

   modport source (
      output valid, operation, slot, all_slots, volume, sound_length, sound_mono,
             sound_id, source_sample, dest_sample_a, dest_sample_b,
      input  ready
   );

   modport sink (
      input  valid, operation, slot, all_slots, volume, sound_length, sound_mono,
             sound_id, source_sample, dest_sample_a, dest_sample_b,
      output ready
   );
endinterface

interface ssm_rsp_if;
   import ssm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mixed_sample;
   logic [STATUS_W-1:0]        slot_status;
   logic                       last;

   modport source (
      output valid, mixed_sample, slot_status, last,
      input  ready
   );

   modport sink (
      input  valid, mixed_sample, slot_status, last,
      output ready
   );
endinterface

// ===== sv/ssm_front.sv =====
`timescale 1ns / 1ps
module ssm_front #(
   parameter int SLOTS       = ssm_pkg::SLOTS_DEFAULT,
   parameter int FULL_VOLUME = ssm_pkg::FULL_VOLUME_DEFAULT
) (
   ssm_req_if.sink             req_bus,
   input  logic                q_full,
   output logic                push,
   output ssm_pkg::ssm_cmd_type cmd
);
   import ssm_pkg::*;

   localparam logic [VOL_W-1:0]  VOL_LIMIT  = VOL_W'(FULL_VOLUME);
   localparam logic [SLOT_W:0]   SLOT_COUNT = (SLOT_W + 1)'(SLOTS);

   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   always_comb begin
      cmd.operation     = req_bus.operation;
      cmd.slot          = req_bus.slot;
      cmd.slot_ok       = {1'b0, req_bus.slot} < SLOT_COUNT;
      cmd.all_slots     = req_bus.all_slots;
      cmd.volume        = (req_bus.volume > VOL_LIMIT) ? VOL_LIMIT : req_bus.volume;
      cmd.sound_length  = req_bus.sound_length;
      cmd.sound_mono    = req_bus.sound_mono;
      cmd.sound_id      = req_bus.sound_id;
      cmd.source_sample = req_bus.source_sample;
      cmd.dest_sample_a = req_bus.dest_sample_a;
      cmd.dest_sample_b = req_bus.dest_sample_b;
   end

endmodule

// ===== sv/ssm_queue.sv =====
`timescale 1ns / 1ps
module ssm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ssm_pkg::ssm_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output ssm_pkg::ssm_cmd_type head_cmd,
   output logic                 empty
);
   import ssm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ssm_cmd_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/ssm_back.sv =====
`timescale 1ns / 1ps
module ssm_back #(
   parameter int SLOTS       = ssm_pkg::SLOTS_DEFAULT,
   parameter int FULL_VOLUME = ssm_pkg::FULL_VOLUME_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  ssm_pkg::ssm_cmd_type head_cmd,
   output logic                 pop,
   ssm_rsp_if.source            rsp_bus
);
   import ssm_pkg::*;

   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAG_W       = SAMPLE_W + VOL_W;
   localparam int PROD_W      = MAG_W + 1;
   localparam int RECIP_SHIFT = MAG_W;
   localparam int RECIP_W     = MAG_W + 1;
   localparam int QUOT_W      = SAMPLE_W + 1;
   localparam int REM_W       = VOL_W + 1;
   localparam int SUM_W       = QUOT_W + 2;

   localparam logic [RECIP_W-1:0] RECIP_V =
      RECIP_W'((64'd1 << RECIP_SHIFT) / FULL_VOLUME);
   localparam logic [VOL_W-1:0]   FULL_VOL_V = VOL_W'(FULL_VOLUME);
   localparam logic [REM_W-1:0]   FULL_VOL_R = REM_W'(FULL_VOLUME);

   localparam logic [2:0] BK_IDLE   = 3'd0;
   localparam logic [2:0] BK_RECIP  = 3'd1;
   localparam logic [2:0] BK_REM    = 3'd2;
   localparam logic [2:0] BK_SUM    = 3'd3;
   localparam logic [2:0] BK_BEAT_B = 3'd4;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > SUM_W'(SAMPLE_MAX)) begin
         r = SAMPLE_MAX;
      end else if (v < SUM_W'(SAMPLE_MIN)) begin
         r = SAMPLE_MIN;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // Slot table.
   logic [STATUS_W-1:0] state_ff  [SLOTS];
   logic [STATUS_W-1:0] state_in  [SLOTS];
   logic [ID_W-1:0]     sound_ff  [SLOTS];
   logic [ID_W-1:0]     sound_in  [SLOTS];
   logic [LEN_W-1:0]    remain_ff [SLOTS];
   logic [LEN_W-1:0]    remain_in [SLOTS];
   logic [VOL_W-1:0]    vol_ff    [SLOTS];
   logic [VOL_W-1:0]    vol_in    [SLOTS];
   logic                mono_ff   [SLOTS];
   logic                mono_in   [SLOTS];

   logic [2:0] bk_ff, bk_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] mixed_ff, mixed_in;
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic                       last_ff, last_in;

   // Scaling pipeline.
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       neg_ff, neg_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [QUOT_W-1:0]          quot_ff, quot_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic signed [SAMPLE_W-1:0] a_ff, a_in;
   logic signed [SAMPLE_W-1:0] b_ff, b_in;
   logic                       mix_mono_ff, mix_mono_in;

   logic                         out_free;
   logic [IDX_W-1:0]             s_idx;
   logic [PROD_W-1:0]            prod_abs;
   logic [MAG_W+RECIP_W-1:0]     recip_prod;
   logic [MAG_W:0]               quot_times_d;
   logic [MAG_W:0]               rem_full;
   logic [QUOT_W-1:0]            q_adj;
   logic signed [QUOT_W:0]       q_mag;
   logic signed [QUOT_W:0]       scaled;
   logic signed [SUM_W-1:0]      sum_a;
   logic signed [SUM_W-1:0]      sum_b;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s_idx    = head_cmd.slot[IDX_W-1:0];

   assign prod_abs   = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign recip_prod = {{RECIP_W{1'b0}}, prod_abs[MAG_W-1:0]} * {{MAG_W{1'b0}}, RECIP_V};

   assign quot_times_d = {{VOL_W{1'b0}}, quot_ff} * {{QUOT_W{1'b0}}, FULL_VOL_V};
   assign rem_full     = {1'b0, mag_ff} - quot_times_d;

   assign q_adj  = quot_ff + QUOT_W'(rem_ff >= FULL_VOL_R);
   assign q_mag  = {1'b0, q_adj};
   assign scaled = neg_ff ? -q_mag : q_mag;
   assign sum_a  = {{(SUM_W - SAMPLE_W){a_ff[SAMPLE_W-1]}}, a_ff}
                 + {{(SUM_W - QUOT_W - 1){scaled[QUOT_W]}}, scaled};
   assign sum_b  = {{(SUM_W - SAMPLE_W){b_ff[SAMPLE_W-1]}}, b_ff}
                 + {{(SUM_W - QUOT_W - 1){scaled[QUOT_W]}}, scaled};

   always_comb begin
      state_in     = state_ff;
      sound_in     = sound_ff;
      remain_in    = remain_ff;
      vol_in       = vol_ff;
      mono_in      = mono_ff;
      bk_in        = bk_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mixed_in     = mixed_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mix_mono_in  = mix_mono_ff;

      unique case (bk_ff)
         BK_IDLE: begin
            if (!q_empty && out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               mixed_in     = '0;
               status_in    = ST_STOPPED;
               last_in      = 1'b1;
               case (head_cmd.operation)
                  OP_PLAY: begin
                     if (head_cmd.slot_ok) begin
                        state_in[s_idx]  = ST_PLAYING;
                        sound_in[s_idx]  = head_cmd.sound_id;
                        remain_in[s_idx] = head_cmd.sound_length;
                        vol_in[s_idx]    = head_cmd.volume;
                        mono_in[s_idx]   = head_cmd.sound_mono;
                     end
                  end
                  OP_STOP: begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if ((head_cmd.all_slots || head_cmd.slot == SLOT_W'(i)) &&
                            state_ff[i] == ST_PLAYING) begin
                           state_in[i]  = ST_STOPPED;
                           sound_in[i]  = '0;
                           remain_in[i] = '0;
                           vol_in[i]    = '0;
                        end
                     end
                  end
                  OP_STOP_ID: begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if (state_ff[i] != ST_STOPPED && sound_ff[i] == head_cmd.sound_id) begin
                           state_in[i]  = ST_STOPPED;
                           sound_in[i]  = '0;
                           remain_in[i] = '0;
                           vol_in[i]    = '0;
                        end
                     end
                  end
                  OP_PAUSE: begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if ((head_cmd.all_slots || head_cmd.slot == SLOT_W'(i)) &&
                            state_ff[i] == ST_PLAYING) begin
                           state_in[i] = ST_PAUSED;
                        end
                     end
                  end
                  OP_RESUME: begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if ((head_cmd.all_slots || head_cmd.slot == SLOT_W'(i)) &&
                            state_ff[i] == ST_PAUSED) begin
                           state_in[i] = ST_PLAYING;
                        end
                     end
                  end
                  OP_QUERY: begin
                     if (head_cmd.slot_ok) begin
                        status_in = state_ff[s_idx];
                     end
                  end
                  OP_MIX: begin
                     if (!head_cmd.slot_ok) begin
                        mixed_in = head_cmd.dest_sample_a;
                     end else if (state_ff[s_idx] == ST_PLAYING && remain_ff[s_idx] != '0) begin
                        // The result comes out of the scaling pipeline.
                        rsp_valid_in     = 1'b0;
                        remain_in[s_idx] = remain_ff[s_idx] - 1'b1;
                        prod_in          = head_cmd.source_sample * signed'({1'b0, vol_ff[s_idx]});
                        a_in             = head_cmd.dest_sample_a;
                        b_in             = head_cmd.dest_sample_b;
                        mix_mono_in      = mono_ff[s_idx];
                        bk_in            = BK_RECIP;
                     end else begin
                        if (state_ff[s_idx] == ST_PLAYING) begin
                           state_in[s_idx]  = ST_STOPPED;
                           sound_in[s_idx]  = '0;
                           remain_in[s_idx] = '0;
                           vol_in[s_idx]    = '0;
                        end
                        mixed_in = head_cmd.dest_sample_a;
                        if (mono_ff[s_idx]) begin
                           last_in = 1'b0;
                           b_in    = head_cmd.dest_sample_b;
                           bk_in   = BK_BEAT_B;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_RECIP: begin
            neg_in  = prod_ff[PROD_W-1];
            mag_in  = prod_abs[MAG_W-1:0];
            quot_in = recip_prod[RECIP_SHIFT +: QUOT_W];
            bk_in   = BK_REM;
         end
         BK_REM: begin
            rem_in = rem_full[REM_W-1:0];
            bk_in  = BK_SUM;
         end
         BK_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mixed_in     = sat16(sum_a);
               status_in    = ST_STOPPED;
               last_in      = !mix_mono_ff;
               b_in         = sat16(sum_b);
               bk_in        = mix_mono_ff ? BK_BEAT_B : BK_IDLE;
            end
         end
         BK_BEAT_B: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mixed_in     = b_ff;
               status_in    = ST_STOPPED;
               last_in      = 1'b1;
               bk_in        = BK_IDLE;
            end
         end
         default: begin
            bk_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            state_ff[i]  <= ST_STOPPED;
            sound_ff[i]  <= '0;
            remain_ff[i] <= '0;
            vol_ff[i]    <= '0;
            mono_ff[i]   <= 1'b0;
         end
         bk_ff        <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sound_ff     <= sound_in;
         remain_ff    <= remain_in;
         vol_ff       <= vol_in;
         mono_ff      <= mono_in;
         bk_ff        <= bk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mixed_ff    <= mixed_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      mix_mono_ff <= mix_mono_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mixed_sample = mixed_ff;
   assign rsp_bus.slot_status  = status_ff;
   assign rsp_bus.last         = last_ff;

endmodule

// ===== sv/sound_slot_mixer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// req_bus   in         one operation with its slot, sound and sample fields
// rsp_bus   out        one result sample or status, last marks the final beat
//
// An operation other than an active mix goes in the back end from the queue head straight
// into the result register; a mono pass-through mix then adds its second beat. An active
// mix runs through the scaling pipeline (product, reciprocal multiply, remainder, correct
// and saturate), and a mono mix then adds its second beat.
// The input side takes beats while the two-entry command queue has room.
// Reset is synchronous and stops every slot.
// A stalled result register holds the back end; the front end keeps filling the queue.
module sound_slot_mixer #(
   parameter int SLOTS       = ssm_pkg::SLOTS_DEFAULT,
   parameter int FULL_VOLUME = ssm_pkg::FULL_VOLUME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ssm_req_if.sink    req_bus,
   ssm_rsp_if.source  rsp_bus
);
   import ssm_pkg::*;

   logic        push;
   logic        pop;
   logic        q_full;
   logic        q_empty;
   ssm_cmd_type push_cmd;
   ssm_cmd_type head_cmd;

   ssm_front #(
      .SLOTS       (SLOTS),
      .FULL_VOLUME (FULL_VOLUME)
   ) u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .push    (push),
      .cmd     (push_cmd)
   );

   ssm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   ssm_back #(
      .SLOTS       (SLOTS),
      .FULL_VOLUME (FULL_VOLUME)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head_cmd (head_cmd),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== sv/ssm_checker.sv =====
`timescale 1ns / 1ps
`include "sound_slot_mixer_macros.svh"
module ssm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ssm_pkg::SAMPLE_W-1:0] rsp_mixed_sample,
   input logic [ssm_pkg::STATUS_W-1:0]        rsp_slot_status,
   input logic                                rsp_last
);
   import ssm_pkg::*;

   // Right after reset the queue is empty and no result is pending.
   `SSM_ASSERT_ALWAYS(a_reset_clean, clock, !reset && $past(reset), req_ready && !rsp_valid)

   `SSM_ASSERT_NEXT(a_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `SSM_ASSERT_NEXT(a_payload_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_mixed_sample) && $stable(rsp_slot_status) && $stable(rsp_last))

   // Only a query reports a slot state, and it is a single zero-sample beat.
   `SSM_ASSERT_NOW(a_query_beat, clock, reset, rsp_valid && rsp_slot_status != ST_STOPPED, rsp_last && rsp_mixed_sample == '0)

   // A beat that is not last belongs to a mono mix and must be followed by its partner.
   `SSM_ASSERT_NEXT(a_mono_pair, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && rsp_last)

endmodule

bind sound_slot_mixer ssm_checker u_ssm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_mixed_sample (rsp_bus.mixed_sample),
   .rsp_slot_status  (rsp_bus.slot_status),
   .rsp_last         (rsp_bus.last)
);

// ===== test/sound_slot_mixer_test.sv =====
`timescale 1ns / 1ps
module sound_slot_mixer_test;
   import ssm_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int FULL_VOLUME  = FULL_VOLUME_DEFAULT;
   localparam int RANDOM_OPS   = 1300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;

   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]            operation;
      logic [SLOT_W-1:0]          slot;
      logic                       all_slots;
      logic [VOL_W-1:0]           volume;
      logic [LEN_W-1:0]           sound_length;
      logic                       sound_mono;
      logic [ID_W-1:0]            sound_id;
      logic signed [SAMPLE_W-1:0] source_sample;
      logic signed [SAMPLE_W-1:0] dest_sample_a;
      logic signed [SAMPLE_W-1:0] dest_sample_b;
   } slot_op_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
      logic [STATUS_W-1:0]        slot_status;
      logic                       last;
   } mix_beat_type;

   typedef struct packed {
      slot_op_type  op;
      logic [1:0]   typed_count;
      mix_beat_type typed0;
      mix_beat_type typed1;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssm_req_if req_bus ();
   ssm_rsp_if rsp_bus ();

   sound_slot_mixer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   logic [STATUS_W-1:0] slot_state     [SLOTS];
   logic [ID_W-1:0]     slot_sound     [SLOTS];
   logic [LEN_W-1:0]    slot_remaining [SLOTS];
   logic [VOL_W-1:0]    slot_volume    [SLOTS];
   logic                slot_is_mono   [SLOTS];

   mix_beat_type expected_beats [$];
   dir_row_type  directed_rows [$];
   mix_beat_type wanted_beat;

   int errors = 0;
   int beats_checked = 0;
   int ops_sent = 0;
   int mix_sent = 0;
   int play_sent = 0;
   int query_sent = 0;
   int holds_done = 0;
   int cycle_count = 0;
   int favored_slot = 0;
   int no_gap_left = 0;
   int rsp_hold_left = 0;
   int rsp_stall_left = 0;
   int rsp_run_left = 0;
   bit long_hold_req = 1'b0;

   function automatic logic signed [SAMPLE_W-1:0] saturate(input int v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return SAMPLE_W'(v);
   endfunction

   function automatic void halt_slot(input int i);
      slot_state[i] = ST_STOPPED;
      slot_sound[i] = '0;
      slot_remaining[i] = '0;
      slot_volume[i] = '0;
   endfunction

   function automatic int predict_slot_op(input slot_op_type op, output mix_beat_type b0,
                                          output mix_beat_type b1);
      logic [SLOT_W-1:0] s;
      bit in_range;
      int src_i;
      int vol_i;
      int scaled;
      s = op.slot;
      in_range = s < SLOTS;
      b0 = '{mixed_sample: '0, slot_status: ST_STOPPED, last: 1'b1};
      b1 = b0;
      case (op.operation)
         OP_PLAY: begin
            if (in_range) begin
               slot_state[s] = ST_PLAYING;
               slot_sound[s] = op.sound_id;
               slot_remaining[s] = op.sound_length;
               slot_volume[s] = (op.volume > FULL_VOLUME) ? VOL_W'(FULL_VOLUME) : op.volume;
               slot_is_mono[s] = op.sound_mono;
            end
         end
         OP_STOP: begin
            for (int i = 0; i < SLOTS; i++)
               if ((op.all_slots || i == s) && slot_state[i] == ST_PLAYING) halt_slot(i);
         end
         OP_STOP_ID: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_state[i] != ST_STOPPED && slot_sound[i] == op.sound_id) halt_slot(i);
         end
         OP_PAUSE: begin
            for (int i = 0; i < SLOTS; i++)
               if ((op.all_slots || i == s) && slot_state[i] == ST_PLAYING)
                  slot_state[i] = ST_PAUSED;
         end
         OP_RESUME: begin
            for (int i = 0; i < SLOTS; i++)
               if ((op.all_slots || i == s) && slot_state[i] == ST_PAUSED)
                  slot_state[i] = ST_PLAYING;
         end
         OP_QUERY: begin
            b0.slot_status = in_range ? slot_state[s] : ST_STOPPED;
         end
         OP_MIX: begin
            b0.mixed_sample = op.dest_sample_a;
            b1.mixed_sample = op.dest_sample_b;
            if (!in_range) return 1;
            if (slot_state[s] == ST_PLAYING && slot_remaining[s] != 0) begin
               src_i = int'(op.source_sample);
               vol_i = int'(slot_volume[s]);
               scaled = src_i * vol_i / FULL_VOLUME;
               slot_remaining[s] = slot_remaining[s] - 1'b1;
               src_i = int'(op.dest_sample_a);
               b0.mixed_sample = saturate(src_i + scaled);
               src_i = int'(op.dest_sample_b);
               b1.mixed_sample = saturate(src_i + scaled);
            end else if (slot_state[s] == ST_PLAYING) begin
               halt_slot(s);
            end
            if (slot_is_mono[s]) begin
               b0.last = 1'b0;
               return 2;
            end
         end
         default: ;
      endcase
      return 1;
   endfunction

   function automatic slot_op_type make_op(input logic [OP_W-1:0] operation,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic all_slots,
                                           input logic [VOL_W-1:0] volume,
                                           input logic [LEN_W-1:0] sound_length,
                                           input logic sound_mono,
                                           input logic [ID_W-1:0] sound_id,
                                           input logic signed [SAMPLE_W-1:0] src,
                                           input logic signed [SAMPLE_W-1:0] da,
                                           input logic signed [SAMPLE_W-1:0] db);
      return '{operation, slot, all_slots, volume, sound_length, sound_mono, sound_id,
               src, da, db};
   endfunction

   function automatic mix_beat_type beat(input logic signed [SAMPLE_W-1:0] sample,
                                         input logic [STATUS_W-1:0] status);
      return '{mixed_sample: sample, slot_status: status, last: 1'b1};
   endfunction

   function automatic dir_row_type make_row(input slot_op_type op, input int typed_count,
                                            input mix_beat_type e0 = '0);
      return '{op: op, typed_count: typed_count[1:0], typed0: e0, typed1: '0};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      if (no_gap_left > 0) begin
         no_gap_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) no_gap_left = $urandom_range(10, 40);
      return pick_gap();
   endfunction

   function automatic logic [SLOT_W-1:0] pick_slot();
      if ($urandom_range(0, 9) == 0) return SLOT_W'($urandom_range(SLOTS, 15));
      return SLOT_W'($urandom_range(0, SLOTS - 1));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return -16'sd1;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly plays followed by mixes on the same slots, so slots run down to zero
   // and stop; the remaining operations shuffle the slot states around them.
   function automatic slot_op_type random_slot_op();
      slot_op_type op;
      int pick;
      op.operation = OP_W'($urandom_range(0, 7));
      op.slot = SLOT_W'($urandom_range(0, 15));
      op.all_slots = 1'($urandom_range(0, 1));
      op.volume = VOL_W'($urandom_range(0, 1023));
      op.sound_length = LEN_W'($urandom_range(0, 24'hFFFFFF));
      op.sound_mono = 1'($urandom_range(0, 1));
      op.sound_id = ID_W'($urandom_range(0, 255));
      op.source_sample = random_sample();
      op.dest_sample_a = random_sample();
      op.dest_sample_b = random_sample();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         op.operation = OP_PLAY;
         op.slot = pick_slot();
         if ($urandom_range(0, 3) != 0) op.volume = VOL_W'($urandom_range(0, 160));
         if ($urandom_range(0, 9) != 0) op.sound_length = LEN_W'($urandom_range(0, 6));
         if ($urandom_range(0, 3) != 0) op.sound_id = ID_W'($urandom_range(0, 3));
         favored_slot = int'(op.slot);
      end else if (pick < 70) begin
         op.operation = OP_MIX;
         op.slot = ($urandom_range(0, 9) < 4) ? SLOT_W'(favored_slot) : pick_slot();
      end else if (pick < 74) begin
         op.operation = OP_STOP;
         op.all_slots = ($urandom_range(0, 4) == 0);
      end else if (pick < 78) begin
         op.operation = OP_STOP_ID;
         if ($urandom_range(0, 3) != 0) op.sound_id = ID_W'($urandom_range(0, 3));
      end else if (pick < 83) begin
         op.operation = OP_PAUSE;
         op.all_slots = ($urandom_range(0, 4) == 0);
      end else if (pick < 88) begin
         op.operation = OP_RESUME;
         op.all_slots = ($urandom_range(0, 4) == 0);
      end else if (pick < 96) begin
         op.operation = OP_QUERY;
      end else begin
         op.operation = OP_UNUSED;
      end
      return op;
   endfunction

   task automatic send_slot_op(input slot_op_type op, input int typed_count,
                               input mix_beat_type e0);
      mix_beat_type p0;
      mix_beat_type p1;
      int n_pred;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.operation <= op.operation;
      req_bus.slot <= op.slot;
      req_bus.all_slots <= op.all_slots;
      req_bus.volume <= op.volume;
      req_bus.sound_length <= op.sound_length;
      req_bus.sound_mono <= op.sound_mono;
      req_bus.sound_id <= op.sound_id;
      req_bus.source_sample <= op.source_sample;
      req_bus.dest_sample_a <= op.dest_sample_a;
      req_bus.dest_sample_b <= op.dest_sample_b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      n_pred = predict_slot_op(op, p0, p1);
      if (typed_count == 0) begin
         expected_beats.push_back(p0);
         if (n_pred == 2) expected_beats.push_back(p1);
      end else begin
         expected_beats.push_back(e0);
      end
      ops_sent++;
      case (op.operation)
         OP_MIX: mix_sent++;
         OP_PLAY: play_sent++;
         OP_QUERY: query_sent++;
         default: ;
      endcase
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      idle_sender(1);
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_hold_left = HOLD_CYCLES;
         holds_done++;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_run_left > 0) begin
         rsp_run_left--;
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(0, 8);
         rsp_stall_left = pick_gap();
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got sample %0d status %0d last %0d",
                     $time, rsp_bus.mixed_sample, rsp_bus.slot_status, rsp_bus.last);
            errors++;
         end else begin
            wanted_beat = expected_beats.pop_front();
            beats_checked++;
            if (rsp_bus.mixed_sample !== wanted_beat.mixed_sample) begin
               $display("%0t: mixed_sample mismatch, expected %0d, got %0d", $time,
                        wanted_beat.mixed_sample, rsp_bus.mixed_sample);
               errors++;
            end
            if (rsp_bus.slot_status !== wanted_beat.slot_status) begin
               $display("%0t: slot_status mismatch, expected %0d, got %0d", $time,
                        wanted_beat.slot_status, rsp_bus.slot_status);
               errors++;
            end
            if (rsp_bus.last !== wanted_beat.last) begin
               $display("%0t: last mismatch, expected %0d, got %0d", $time,
                        wanted_beat.last, rsp_bus.last);
               errors++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = OP_PLAY;
      req_bus.slot = '0;
      req_bus.all_slots = 1'b0;
      req_bus.volume = '0;
      req_bus.sound_length = '0;
      req_bus.sound_mono = 1'b0;
      req_bus.sound_id = '0;
      req_bus.source_sample = '0;
      req_bus.dest_sample_a = '0;
      req_bus.dest_sample_b = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_state[i] = ST_STOPPED;
         slot_sound[i] = '0;
         slot_remaining[i] = '0;
         slot_volume[i] = '0;
         slot_is_mono[i] = 1'b0;
      end

      directed_rows.push_back(make_row(make_op(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 3, 0, 0, 0, 0, 0, 32767, -32768, 5),
                                       1, beat(-32768, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_UNUSED, 15, 1, 10'h3FF, 24'hFFFFFF, 1,
                                               8'hFF, -1, -1, -1),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 15, 0, 0, 0, 1, 0, 100, 12345, 7),
                                       1, beat(12345, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_QUERY, 12, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_PLAY, 0, 0, 10'h3FF, 3, 0, 8'hFF, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_PLAYING)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 0, 0, 0, 0, 0, 0, 32767, 32767, 0),
                                       1, beat(32767, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 0, 0, 0, 0, 0, 0, -32768, -32768, 0),
                                       1, beat(-32768, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 0, 0, 0, 0, 0, 0, -1, 0, 0), 0));
      directed_rows.push_back(make_row(make_op(OP_MIX, 0, 0, 0, 0, 0, 0, 500, -77, 3), 0));
      directed_rows.push_back(make_row(make_op(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_PLAY, 7, 0, 0, 24'hFFFFFF, 1, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 7, 0, 0, 0, 0, 0, 32767, 100, -100),
                                       0));
      directed_rows.push_back(make_row(make_op(OP_PLAY, 1, 0, 127, 5, 1, 8'h5A, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 1, 0, 0, 0, 0, 0, -32768, -1, 32767),
                                       0));
      directed_rows.push_back(make_row(make_op(OP_PAUSE, 1, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_PAUSED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 1, 0, 0, 0, 0, 0, 9999, 40, -40), 0));
      directed_rows.push_back(make_row(make_op(OP_STOP, 1, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_STOP_ID, 4, 0, 0, 0, 0, 8'h5A, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_MIX, 1, 0, 0, 0, 0, 0, 1, 32767, -32768),
                                       0));
      directed_rows.push_back(make_row(make_op(OP_PAUSE, 12, 1, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_RESUME, 9, 1, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));
      directed_rows.push_back(make_row(make_op(OP_STOP, 13, 1, 0, 0, 0, 0, 0, 0, 0),
                                       1, beat(0, ST_STOPPED)));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_slot_op(directed_rows[i].op, directed_rows[i].typed_count,
                      directed_rows[i].typed0);
         idle_sender(sender_gap());
      end
      drain_results();

      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == 300 || n == 900) long_hold_req = 1'b1;
         if (n == 600 || n == 1100) drain_results();
         send_slot_op(random_slot_op(), 0, '0);
         idle_sender(sender_gap());
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d operations (%0d mix, %0d play, %0d query), checked %0d beats.",
               ops_sent, mix_sent, play_sent, query_sent, beats_checked);
      $display("Result side held off %0d times for %0d cycles; %0d cycles in total.",
               holds_done, HOLD_CYCLES, cycle_count);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
